### hw/rtl/kli_pkg.sv
// Shared types and constants for the keyframe linear interpolator.
`default_nettype none

package kli_pkg;

    localparam int LANES     = 3;
    localparam int DIV_BITS  = 33;
    localparam int DIV_CNT_W = 6;
    localparam logic [15:0] STEPS_RESET = 16'd100;

    typedef logic signed [31:0] t_q16;
    typedef logic [LANES-1:0][31:0] t_vec3;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_PLAY  = 3'd1,
        CMD_PAUSE = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_RESET = 3'd4,
        CMD_TICK  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        REG_STEPS = 2'd0,
        REG_LOOP  = 2'd1,
        REG_KEYS  = 2'd2
    } t_reg;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_lane_res;

endpackage

`default_nettype wire

### hw/rtl/kli_div_lane.sv
// One divider lane: signed by unsigned restoring division, one quotient bit per cycle.
`default_nettype none

module kli_div_lane import kli_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [DIV_BITS-1:0] i_dividend,
    input  logic [15:0]                i_divisor,
    output t_lane_res                  o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_BITS-1:0]  r_dvd;
    logic [15:0]          r_rem;

    logic [DIV_BITS-1:0]  mag;
    logic [DIV_BITS-1:0]  qs;
    logic [16:0]          trial;
    logic [16:0]          diff;
    logic                 fits;

    assign mag   = i_dividend[DIV_BITS-1] ? (~i_dividend + DIV_BITS'(1)) : i_dividend;
    assign trial = {r_rem, r_dvd[DIV_BITS-1]};
    assign fits  = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};
    assign qs    = r_neg ? (~r_dvd + DIV_BITS'(1)) : r_dvd;

    assign o_res.done = r_done;
    assign o_res.quot = qs[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= mag;
            r_rem <= 16'd0;
            r_neg <= i_dividend[DIV_BITS-1];
            r_cnt <= DIV_CNT_W'(DIV_BITS);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_BITS-2:0], fits};
            r_rem <= fits ? diff[15:0] : trial[15:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kli_merge.sv
// Merge stage: collects the lane quotients into one increment vector.
`default_nettype none

module kli_merge import kli_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_res [LANES-1:0] i_res,
    input  logic                  i_div_zero,
    output logic                  o_valid,
    output t_vec3                 o_inc
);

    logic  r_valid;
    t_vec3 r_inc;
    logic  all_done;

    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            all_done = all_done & i_res[i].done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= all_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (all_done) begin
            for (int i = 0; i < LANES; i++) begin
                r_inc[i] <= i_div_zero ? 32'd0 : i_res[i].quot;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_inc   = r_inc;

endmodule

`default_nettype wire

### hw/rtl/keyframe_linear_interpolator.sv
// Keyframe linear interpolator top level: command sequencer, key memory and divider lanes.
// Commands without a segment start raise o_done from S_EXEC. A segment start (play,
// stop, reset, segment change) passes S_RD and S_DAT, then waits in S_DIV for the
// bit-serial dividers that run in three parallel lanes; with no next key it ends in S_DAT.
// One item at a time; start is taken again in the cycle o_done is high.
// Reset (i_rst_n low, synchronous) clears state and registers; key memory is not cleared.
`default_nettype none

module keyframe_linear_interpolator import kli_pkg::*; #(
    parameter int MAX_KEYS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_key_index,
    input  t_q16        i_key_a,
    input  t_q16        i_key_b,
    input  t_q16        i_key_c,
    output logic        o_done,
    output t_q16        o_value_a,
    output t_q16        o_value_b,
    output t_q16        o_value_c,
    output logic [5:0]  o_segment,
    output logic        o_playing,
    output logic        o_finished,
    output logic        o_play_refused
);

    localparam int KW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RD   = 5'b00100,
        S_DAT  = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    t_state         r_state;
    logic [15:0]    r_sps;
    logic           r_loop;
    logic [6:0]     r_kc;
    logic           r_play;
    logic [KW-1:0]  r_seg;
    logic [15:0]    r_step;
    t_vec3          r_val;
    t_vec3          r_inc;
    logic           r_done;
    logic           r_fin;
    logic           r_ref;
    logic           r_rew;
    logic           r_lane_go;

    t_cmd           r_cmd;
    logic [5:0]     r_idx;
    t_vec3          r_key;
    t_vec3          r_rd_a;
    t_vec3          r_rd_b;
    t_vec3          mem [MAX_KEYS];

    logic [NW-1:0]  keys_n;
    logic [31:0]    n_last;
    logic           n_ok;
    logic [KW:0]    seg_inc;
    logic           seg_at_end;
    logic           inc_at_end;
    logic           rec_ok;
    logic           ld_ok;
    t_vec3          sum;

    t_lane_res [LANES-1:0] lane_res;
    logic           mrg_valid;
    t_vec3          mrg_inc;

    assign keys_n     = (32'(r_kc) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(r_kc);
    assign n_last     = 32'(keys_n) - 32'd1;
    assign n_ok       = 32'(keys_n) >= 32'd2;
    assign seg_inc    = (KW+1)'(r_seg) + (KW+1)'(1);
    assign seg_at_end = 32'(r_seg) >= n_last;
    assign inc_at_end = 32'(seg_inc) >= n_last;
    assign rec_ok     = n_ok && (32'(r_seg) < n_last);
    assign ld_ok      = 32'(r_idx) < MAX_KEYS;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sum[i] = r_val[i] + r_inc[i];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic signed [DIV_BITS-1:0] dvd;

        assign dvd = $signed({r_rd_b[g][31], r_rd_b[g]}) - $signed({r_rd_a[g][31], r_rd_a[g]});

        kli_div_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_lane_go),
            .i_dividend (dvd),
            .i_divisor  (r_sps),
            .o_res      (lane_res[g])
        );
    end

    kli_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (lane_res),
        .i_div_zero (r_sps == 16'd0),
        .o_valid    (mrg_valid),
        .o_inc      (mrg_inc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sps     <= STEPS_RESET;
            r_loop    <= 1'b0;
            r_kc      <= 7'd0;
            r_play    <= 1'b0;
            r_seg     <= '0;
            r_step    <= 16'd0;
            r_val     <= '0;
            r_inc     <= '0;
            r_done    <= 1'b0;
            r_fin     <= 1'b0;
            r_ref     <= 1'b0;
            r_rew     <= 1'b0;
            r_lane_go <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_lane_go <= 1'b0;

            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_STEPS: r_sps  <= i_cfg_data;
                    REG_LOOP:  r_loop <= i_cfg_data[0];
                    REG_KEYS:  r_kc   <= i_cfg_data[6:0];
                    default:   ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_fin   <= 1'b0;
                        r_ref   <= 1'b0;
                        r_rew   <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    case (r_cmd)
                        CMD_LOAD: begin
                            if (ld_ok && r_idx == 6'd0 && !r_play) begin
                                r_val <= r_key;
                            end
                        end
                        CMD_PLAY: begin
                            if (!n_ok) begin
                                r_ref <= 1'b1;
                            end else if (!r_play) begin
                                r_play <= 1'b1;
                                if (seg_at_end) begin
                                    r_seg  <= '0;
                                    r_step <= 16'd0;
                                    r_rew  <= 1'b1;
                                end
                                r_state <= S_RD;
                                r_done  <= 1'b0;
                            end
                        end
                        CMD_PAUSE: begin
                            r_play <= 1'b0;
                        end
                        CMD_STOP, CMD_RESET: begin
                            if (r_cmd == CMD_STOP) begin
                                r_play <= 1'b0;
                            end
                            r_seg   <= '0;
                            r_step  <= 16'd0;
                            r_rew   <= 1'b1;
                            r_state <= S_RD;
                            r_done  <= 1'b0;
                        end
                        CMD_TICK: begin
                            if (r_play && n_ok) begin
                                if (r_step >= r_sps) begin
                                    if (inc_at_end && r_loop) begin
                                        r_seg   <= '0;
                                        r_step  <= 16'd0;
                                        r_rew   <= 1'b1;
                                        r_state <= S_RD;
                                        r_done  <= 1'b0;
                                    end else if (inc_at_end) begin
                                        r_seg  <= seg_inc[KW-1:0];
                                        r_play <= 1'b0;
                                        r_fin  <= 1'b1;
                                    end else begin
                                        r_seg   <= seg_inc[KW-1:0];
                                        r_step  <= 16'd0;
                                        r_state <= S_RD;
                                        r_done  <= 1'b0;
                                    end
                                end else begin
                                    r_val  <= sum;
                                    r_step <= r_step + 16'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_RD: begin
                    r_state <= S_DAT;
                end
                S_DAT: begin
                    if (r_rew) begin
                        r_val <= r_rd_a;
                    end
                    if (rec_ok) begin
                        r_lane_go <= 1'b1;
                        r_state   <= S_DIV;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (mrg_valid) begin
                        r_inc   <= mrg_inc;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd    <= t_cmd'(i_command);
            r_idx    <= i_key_index;
            r_key[0] <= i_key_a;
            r_key[1] <= i_key_b;
            r_key[2] <= i_key_c;
        end
        if (r_state == S_EXEC && r_cmd == CMD_LOAD && ld_ok) begin
            mem[KW'(r_idx)] <= r_key;
        end
        r_rd_a <= mem[r_seg];
        r_rd_b <= mem[seg_inc[KW-1:0]];
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_value_a      = r_val[0];
    assign o_value_b      = r_val[1];
    assign o_value_c      = r_val[2];
    assign o_segment      = 6'(r_seg);
    assign o_playing      = r_play;
    assign o_finished     = r_fin;
    assign o_play_refused = r_ref;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted item did not start");

    a_fin_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_finished |-> !o_playing)
        else $error("finished while playing");

    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_res[0].done |-> (lane_res[1].done && lane_res[2].done && r_state == S_DIV))
        else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire

### tb/keyframe_linear_interpolator_checker.sv
`timescale 1ns / 100ps
// Checker for the keyframe interpolator: predicts each item's status and compares results.
module keyframe_linear_interpolator_checker import kli_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_key_index,
    input  t_q16        i_key_a,
    input  t_q16        i_key_b,
    input  t_q16        i_key_c,
    input  logic        i_done,
    input  t_q16        i_value_a,
    input  t_q16        i_value_b,
    input  t_q16        i_value_c,
    input  logic [5:0]  i_segment,
    input  logic        i_playing,
    input  logic        i_finished,
    input  logic        i_play_refused,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_PRINT   = 100;

    typedef struct {
        t_vec3      values;
        logic [5:0] segment;
        logic       playing;
        logic       finished;
        logic       refused;
    } t_status;

    t_vec3       key_table [TABLE_DEPTH];
    t_vec3       increment;
    t_vec3       current;
    int unsigned seg_idx;
    logic [15:0] step_cnt;
    logic        play_on;
    logic [15:0] steps_cfg;
    logic        loop_cfg;
    logic [6:0]  keys_cfg;
    t_status     status_q[$];
    int          fail_cnt = 0;
    int          result_cnt = 0;

    function automatic int unsigned valid_keys();
        return (keys_cfg > TABLE_DEPTH) ? TABLE_DEPTH : keys_cfg;
    endfunction

    // per-lane (next key - this key) / steps, truncated toward zero
    task automatic refresh_increment();
        int unsigned n;
        longint      diff;
        longint      quot;
        int          c;
        n = valid_keys();
        if (n < 2 || seg_idx >= n - 1)
            return;
        for (c = 0; c < LANES; c++) begin
            diff = longint'($signed(key_table[seg_idx + 1][c])) -
                   longint'($signed(key_table[seg_idx][c]));
            quot = (steps_cfg == 0) ? 64'sd0 : diff / longint'(steps_cfg);
            increment[c] = quot[31:0];
        end
    endtask

    task automatic rewind();
        seg_idx  = 0;
        step_cnt = '0;
        current  = key_table[0];
    endtask

    task automatic apply_item(input logic [2:0] cmd, input logic [5:0] idx, input t_vec3 key,
                              output t_status st);
        int unsigned n;
        int          c;
        logic        ended;
        logic        refused;
        n       = valid_keys();
        ended   = 1'b0;
        refused = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                key_table[idx] = key;
                if (idx == 0 && !play_on)
                    current = key;
            end
            CMD_PLAY: begin
                if (n < 2) begin
                    refused = 1'b1;
                end else if (!play_on) begin
                    play_on = 1'b1;
                    if (seg_idx >= n - 1)
                        rewind();
                    refresh_increment();
                end
            end
            CMD_PAUSE: play_on = 1'b0;
            CMD_STOP: begin
                play_on = 1'b0;
                rewind();
                refresh_increment();
            end
            CMD_RESET: begin
                rewind();
                refresh_increment();
            end
            CMD_TICK: begin
                if (play_on && n >= 2) begin
                    if (step_cnt >= steps_cfg) begin
                        seg_idx++;
                        if (seg_idx >= n - 1) begin
                            if (loop_cfg) begin
                                rewind();
                                refresh_increment();
                            end else begin
                                play_on = 1'b0;
                                ended   = 1'b1;
                            end
                        end else begin
                            step_cnt = '0;
                            refresh_increment();
                        end
                    end else begin
                        for (c = 0; c < LANES; c++)
                            current[c] = current[c] + increment[c];
                        step_cnt = step_cnt + 16'd1;
                    end
                end
            end
            default: ;
        endcase
        st.values   = current;
        st.segment  = seg_idx[5:0];
        st.playing  = play_on;
        st.finished = ended;
        st.refused  = refused;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_cnt < MAX_PRINT)
            $display("[%0t] result %0d %s: got %h, expected %h",
                     $time, result_cnt, field, got, want);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_status want;
        t_vec3   kv;
        if (!i_rst_n) begin
            current   = '0;
            increment = '0;
            seg_idx   = 0;
            step_cnt  = '0;
            play_on   = 1'b0;
            steps_cfg = STEPS_RESET;
            loop_cfg  = 1'b0;
            keys_cfg  = '0;
            status_q.delete();
        end else begin
            if (i_done !== 1'b0) begin
                result_cnt++;
                if (status_q.size() == 0) begin
                    report_mismatch("result with no item pending", i_value_a, '0);
                end else begin
                    want = status_q.pop_front();
                    if (i_value_a !== want.values[0])
                        report_mismatch("value_a", i_value_a, want.values[0]);
                    if (i_value_b !== want.values[1])
                        report_mismatch("value_b", i_value_b, want.values[1]);
                    if (i_value_c !== want.values[2])
                        report_mismatch("value_c", i_value_c, want.values[2]);
                    if (i_segment !== want.segment)
                        report_mismatch("segment", i_segment, want.segment);
                    if (i_playing !== want.playing)
                        report_mismatch("playing", i_playing, want.playing);
                    if (i_finished !== want.finished)
                        report_mismatch("finished", i_finished, want.finished);
                    if (i_play_refused !== want.refused)
                        report_mismatch("play_refused", i_play_refused, want.refused);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STEPS: steps_cfg = i_cfg_data;
                    REG_LOOP:  loop_cfg  = i_cfg_data[0];
                    REG_KEYS:  keys_cfg  = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                kv[0] = i_key_a;
                kv[1] = i_key_b;
                kv[2] = i_key_c;
                apply_item(i_command, i_key_index, kv, want);
                status_q = {status_q, want};
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= status_q.size();
    end

endmodule

### tb/keyframe_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives commands and register writes into the interpolator and gives the verdict.
module keyframe_linear_interpolator_tb;
    import kli_pkg::*;

    localparam int ITEMS         = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 48;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic [2:0]  i_command = '0;
    logic [5:0]  i_key_index = '0;
    t_q16        i_key_a = '0;
    t_q16        i_key_b = '0;
    t_q16        i_key_c = '0;
    logic        o_done;
    t_q16        o_value_a;
    t_q16        o_value_b;
    t_q16        o_value_c;
    logic [5:0]  o_segment;
    logic        o_playing;
    logic        o_finished;
    logic        o_play_refused;

    int          fail_count;
    int          pending;
    logic [63:0] key_written = '0;
    int          items_sent = 0;
    logic        burst = 1'b0;

    always #5 i_clk = ~i_clk;

    keyframe_linear_interpolator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_key_index    (i_key_index),
        .i_key_a        (i_key_a),
        .i_key_b        (i_key_b),
        .i_key_c        (i_key_c),
        .o_done         (o_done),
        .o_value_a      (o_value_a),
        .o_value_b      (o_value_b),
        .o_value_c      (o_value_c),
        .o_segment      (o_segment),
        .o_playing      (o_playing),
        .o_finished     (o_finished),
        .o_play_refused (o_play_refused)
    );

    keyframe_linear_interpolator_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_key_index    (i_key_index),
        .i_key_a        (i_key_a),
        .i_key_b        (i_key_b),
        .i_key_c        (i_key_c),
        .i_done         (o_done),
        .i_value_a      (o_value_a),
        .i_value_b      (o_value_b),
        .i_value_c      (o_value_c),
        .i_segment      (o_segment),
        .i_playing      (o_playing),
        .i_finished     (o_finished),
        .i_play_refused (o_play_refused),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic t_q16 rand_q16();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // start stays high across back-to-back items; it drops only for a gap or in settle
    task automatic send_item(input logic [2:0] cmd, input logic [5:0] idx,
                             input t_q16 a, input t_q16 b, input t_q16 c);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_key_index <= idx;
        i_key_a     <= a;
        i_key_b     <= b;
        i_key_c     <= c;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (cmd == CMD_LOAD)
            key_written[idx] = 1'b1;
        items_sent++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_item(cmd, 6'($urandom_range(0, 63)), rand_q16(), rand_q16(), rand_q16());
    endtask

    task automatic load_key(input logic [5:0] idx);
        send_item(CMD_LOAD, idx, rand_q16(), rand_q16(), rand_q16());
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int          prefix;
        int          body;
        int          phase;
        int          r;
        int          i;
        logic [15:0] steps;
        logic [6:0]  kc;
        logic        loop_on;
        logic [31:0] junk;
        logic        full_loaded;
        logic        force_max;

        phase       = 0;
        full_loaded = 1'b0;
        force_max   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no keys yet: play refused, tick idle, spare codes ignored
        send_cmd(CMD_PLAY);
        send_cmd(CMD_TICK);
        send_cmd(CMD_SPARE_6);
        send_cmd(CMD_SPARE_7);
        send_cmd(CMD_PAUSE);
        send_item(CMD_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_LOAD, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 6'd2, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_item(CMD_LOAD, 6'd3, 32'h0003_0000, 32'h8000_0001, 32'h7FFF_FFFE);
        load_key(6'd63);
        send_cmd(CMD_RESET);
        send_cmd(CMD_STOP);

        settle();
        write_reg(REG_KEYS, 16'd1);
        send_cmd(CMD_PLAY);

        // one step per segment through four keys, then the end of playback
        settle();
        write_reg(REG_STEPS, 16'd1);
        write_reg(REG_LOOP, 16'd0);
        write_reg(REG_KEYS, 16'd4);
        send_cmd(CMD_PLAY);
        repeat (6) send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_PLAY);
        send_cmd(CMD_PAUSE);
        send_cmd(CMD_PLAY);
        load_key(6'd0);
        send_cmd(CMD_STOP);

        while (items_sent < ITEMS) begin
            settle();
            prefix = 0;
            while (prefix < 64 && key_written[prefix]) prefix++;
            case (phase % 6)
                1: steps = '0;
                4: steps = 16'hFFFF;
                default: steps = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 40))
                                                              : 16'($urandom_range(1, 6));
            endcase
            loop_on = 1'($urandom_range(0, 1));
            if (force_max)
                kc = 7'd127;
            else if (prefix == 64 && $urandom_range(0, 3) == 0)
                kc = 7'($urandom_range(64, 127));
            else if ($urandom_range(0, 7) == 0)
                kc = 7'($urandom_range(0, 1));
            else
                kc = 7'($urandom_range(2, prefix));
            force_max = 1'b0;
            junk = $urandom;
            write_reg(REG_STEPS, steps);
            write_reg(REG_LOOP, {junk[14:0], loop_on});
            write_reg(REG_KEYS, {junk[24:16], kc});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, junk[31:16]);
            burst = ($urandom_range(0, 3) == 0);

            if (!full_loaded && items_sent >= 150) begin
                for (i = 0; i < 64; i++) load_key(6'(i));
                full_loaded = 1'b1;
                force_max   = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(2, 8);
                for (i = 0; i < r; i++) load_key(6'(i));
            end

            send_cmd(CMD_PLAY);
            body = $urandom_range(20, 60);
            repeat (body) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_cmd(CMD_TICK);
                else if (r < 66)
                    send_cmd(CMD_PLAY);
                else if (r < 71)
                    send_cmd(CMD_PAUSE);
                else if (r < 75)
                    send_cmd(CMD_STOP);
                else if (r < 79)
                    send_cmd(CMD_RESET);
                else if (r < 95)
                    load_key(6'($urandom_range(0, 63)));
                else if (r < 97)
                    send_cmd(CMD_SPARE_6);
                else
                    send_cmd(CMD_SPARE_7);
            end
            burst = 1'b0;
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("keyframe_linear_interpolator regression: pass");
        else
            $display("keyframe_linear_interpolator regression: fail");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("keyframe_linear_interpolator regression: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/kli_pkg.sv
hw/rtl/kli_div_lane.sv
hw/rtl/kli_merge.sv
hw/rtl/keyframe_linear_interpolator.sv
tb/keyframe_linear_interpolator_checker.sv
tb/keyframe_linear_interpolator_tb.sv
